### rtl/speck_pkg.sv
// Shared types and constants for the Speck 96/96 cipher block.
package speck_pkg;

    localparam int WORD_W    = 48;
    localparam int ROUNDS    = 28;
    localparam int KEY_AW    = $clog2(ROUNDS);
    localparam int ROT_ALPHA = 8;
    localparam int ROT_BETA  = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_AW-1:0] t_kaddr;

    localparam t_kaddr LAST_ROUND = t_kaddr'(ROUNDS - 1);

    // Operation carried on the input tuser bit.
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_KEY_L = 1'b0;
    localparam logic CFG_KEY_K = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

### rtl/speck_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module speck_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/speck_round.sv
// One Speck round, forward or inverse; the forward round also serves the key schedule.
module speck_round
    import speck_pkg::*;
(
    input  logic  i_op,
    input  t_word i_x,
    input  t_word i_y,
    input  t_word i_key,
    output t_word o_x,
    output t_word o_y
);

    t_word x_ror;
    t_word enc_x;
    t_word enc_y;
    t_word xy;
    t_word dec_y;
    t_word dec_d;
    t_word dec_x;

    // Forward round: x = (ror8(x) + y) ^ k, y = rol3(y) ^ x.
    assign x_ror = {i_x[ROT_ALPHA-1:0], i_x[WORD_W-1:ROT_ALPHA]};
    assign enc_x = (x_ror + i_y) ^ i_key;
    assign enc_y = {i_y[WORD_W-1-ROT_BETA:0], i_y[WORD_W-1:WORD_W-ROT_BETA]} ^ enc_x;

    // Inverse round: y = ror3(x ^ y), x = rol8((x ^ k) - y).
    assign xy    = i_x ^ i_y;
    assign dec_y = {xy[ROT_BETA-1:0], xy[WORD_W-1:ROT_BETA]};
    assign dec_d = (i_x ^ i_key) - dec_y;
    assign dec_x = {dec_d[WORD_W-1-ROT_ALPHA:0], dec_d[WORD_W-1:WORD_W-ROT_ALPHA]};

    assign o_x = (i_op == OP_DEC) ? dec_x : enc_x;
    assign o_y = (i_op == OP_DEC) ? dec_y : enc_y;

endmodule

### rtl/speck96_96_block_cipher.sv
// Top level of the Speck 96/96 block cipher with a round-key memory.
//
// Speck 96/96 encrypts or decrypts one 96-bit block (two 48-bit words) per
// item, selected by the tuser bit (0 encrypt, 1 decrypt). The two key words
// are written over the configuration port while the block is idle and no
// item is offered; the first
// item after reset or after any key write first expands the 28 round keys
// into a small key memory, one key per cycle. After that, each item has
// its first round key prefetched from the key memory, runs its 28 rounds
// through the single shared round unit (one round per cycle, the key for
// each round read during the round before it), and then moves its result
// into the output register, a move that waits while an untaken result is
// still there. The block is idle again in the cycle the result is posted,
// so a new item is taken only after the previous result has been posted.
// The round unit also computes the key schedule, since a key step is a
// forward round on the key words. The input accepts a new item while a
// finished result still waits in the output register. The key memory has
// no reset; it is always filled before use.
module speck96_96_block_cipher
    import speck_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [95:0]   i_s_tdata,   // [47:0] block_x, [95:48] block_y
    input  logic          i_s_tuser,   // [0] opcode
    // Output stream.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [95:0]   o_m_tdata,   // [47:0] out_x, [95:48] out_y
    // Configuration writes.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [47:0]   i_cfg_data
);

    t_state r_state;
    t_state n_state;

    // Block words under work, the operation, and the round or key counter.
    t_word  r_x;
    t_word  r_y;
    logic   r_op;
    t_kaddr r_cnt;

    // Key schedule working words.
    t_word  r_lw;
    t_word  r_kw;

    // Configured key words and the flag that the key memory matches them.
    t_word  r_key_l;
    t_word  r_key_k;
    logic   r_keys_ready;

    // Output register.
    logic   r_out_valid;
    t_word  r_out_x;
    t_word  r_out_y;

    logic   s_accept;
    logic   cfg_accept;
    logic   out_free;
    logic   cnt_last;

    // Control decoded from the state.
    logic   key_we;
    logic   sel_sched;
    t_kaddr key_raddr;

    logic   rnd_op;
    t_word  rnd_x_in;
    t_word  rnd_y_in;
    t_word  rnd_key;
    t_word  rnd_x;
    t_word  rnd_y;
    t_word  key_rdata;

    // Decryption uses the round keys in reverse order.
    function automatic t_kaddr key_addr(input logic op, input t_kaddr c);
        key_addr = (op == OP_DEC) ? LAST_ROUND - c : c;
    endfunction

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign cnt_last   = (r_cnt == LAST_ROUND);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = r_keys_ready ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (cnt_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs. During a run the key for the next round is read in
    // the round before it, so it arrives from the memory exactly when it is
    // needed. A key write is held off while an item is offered, so that an
    // item never starts in the same cycle as a key change.
    always_comb begin
        o_s_tready  = 1'b0;
        o_cfg_ready = 1'b0;
        key_we      = 1'b0;
        sel_sched   = 1'b0;
        key_raddr   = key_addr(r_op, '0);
        case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cfg_ready = !i_s_tvalid;
            end
            ST_EXPAND: begin
                key_we    = 1'b1;
                sel_sched = 1'b1;
            end
            ST_LOAD: begin
                key_raddr = key_addr(r_op, '0);
            end
            ST_RUN: begin
                if (!cnt_last) begin
                    key_raddr = key_addr(r_op, r_cnt + t_kaddr'(1));
                end
            end
            ST_DONE: begin
                key_raddr = key_addr(r_op, '0);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    speck_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROUNDS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_cnt),
        .i_wdata (r_kw),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // A key schedule step is a forward round with l as x, k as y and the
    // step number as the round key.
    assign rnd_op   = sel_sched ? OP_ENC : r_op;
    assign rnd_x_in = sel_sched ? r_lw : r_x;
    assign rnd_y_in = sel_sched ? r_kw : r_y;
    assign rnd_key  = sel_sched ? t_word'(r_cnt) : key_rdata;

    speck_round u_round (
        .i_op  (rnd_op),
        .i_x   (rnd_x_in),
        .i_y   (rnd_y_in),
        .i_key (rnd_key),
        .o_x   (rnd_x),
        .o_y   (rnd_y)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_key_l      <= '0;
            r_key_k      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (s_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_EXPAND || r_state == ST_RUN) begin
                r_cnt <= cnt_last ? '0 : r_cnt + t_kaddr'(1);
            end

            if (cfg_accept) begin
                case (i_cfg_index)
                    CFG_KEY_L: r_key_l <= i_cfg_data;
                    CFG_KEY_K: r_key_k <= i_cfg_data;
                    default:   r_key_l <= r_key_l;
                endcase
                r_keys_ready <= 1'b0;
            end else if (r_state == ST_EXPAND && cnt_last) begin
                r_keys_ready <= 1'b1;
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x  <= i_s_tdata[WORD_W-1:0];
            r_y  <= i_s_tdata[2*WORD_W-1:WORD_W];
            r_op <= i_s_tuser;
            r_lw <= r_key_l;
            r_kw <= r_key_k;
        end else if (r_state == ST_EXPAND) begin
            r_lw <= rnd_x;
            r_kw <= rnd_y;
        end else if (r_state == ST_RUN) begin
            r_x <= rnd_x;
            r_y <= rnd_y;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_y, r_out_x};

endmodule

### rtl/speck_chk.sv
// Port-level checks for the Speck 96/96 cipher block, bound to the top level.
module speck_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata,
    input logic        o_cfg_ready
);

    // An accepted item keeps the block busy, keys locked, through all rounds.
    a_busy_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (!o_s_tready && !o_cfg_ready) ##27 !o_s_tready)
        else $error("block took a new item before its rounds were done");

    // No result can appear right after an item is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after an item was taken");

    // The block is free again as soon as a result moves to the output.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("block not ready when its result was posted");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind speck96_96_block_cipher speck_chk u_speck_chk (.*);
